/* hdl/sha1sh_pkg.sv */
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types, constants and helpers of the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

   // Round constants, one for each group of twenty rounds.
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   // Initial chaining value.
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hc3d2e1f0;

   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam int         ROUNDS      = 80;
   localparam int         BLOCK_BYTES = 64;
   localparam int         BLOCK_WORDS = 16;
   localparam int         DIGEST_WORDS = 5;
   localparam logic [5:0] LEN_START   = 6'd56;
   localparam logic [6:0] LAST_ROUND  = 7'd79;
   localparam logic [2:0] MAX_BYTES   = 3'd4;
   localparam logic [2:0] LAST_INDEX  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP_DATA,
      ST_REST,
      ST_PAD,
      ST_COMP_PAD,
      ST_LEN,
      ST_COMP_FINAL,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rest;
      logic pad;
      logic len;
      logic round;
      logic out_next;
      logic reinit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic rem_nz;
      logic last_round;
      logic pad_two;
      logic out_last;
   } sts_type;

   function automatic logic [31:0] rotl1(input logic [31:0] v);
      rotl1 = {v[30:0], v[31]};
   endfunction

   function automatic logic [31:0] rotl5(input logic [31:0] v);
      rotl5 = {v[26:0], v[31:27]};
   endfunction

   function automatic logic [31:0] rotl30(input logic [31:0] v);
      rotl30 = {v[1:0], v[31:2]};
   endfunction

endpackage

/* hdl/sha1sh_if.sv */
// ----------------------------------------------------------------------------
// sha1sh interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
interface sha1sh_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        last_word;

   modport source (output valid, data_word, valid_bytes, last_word, input ready);
   modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha1sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_result;

   modport source (output valid, digest_word, word_index, last_result, input ready);
   modport sink   (input valid, digest_word, word_index, last_result, output ready);
endinterface

/* hdl/sha1sh_datapath.sv */
// ----------------------------------------------------------------------------
// sha1sh_datapath
// Block buffer and message schedule, round logic, chaining value and length.
// ----------------------------------------------------------------------------
module sha1sh_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sha1sh_pkg::cmd_type cmd,
   output sha1sh_pkg::sts_type sts,
   input  logic [31:0]         req_data_word,
   input  logic [2:0]          req_valid_bytes,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_result
);

   logic [31:0] h_ff    [sha1sh_pkg::DIGEST_WORDS];
   logic [31:0] h_in    [sha1sh_pkg::DIGEST_WORDS];
   logic [31:0] wv_ff   [sha1sh_pkg::DIGEST_WORDS];
   logic [31:0] wv_in   [sha1sh_pkg::DIGEST_WORDS];
   logic [31:0] wbuf_ff [sha1sh_pkg::BLOCK_WORDS];
   logic [31:0] wbuf_in [sha1sh_pkg::BLOCK_WORDS];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [6:0]  round_ff, round_in;
   logic [31:0] pend_ff, pend_in;
   logic [2:0]  rem_ff, rem_in;
   logic [1:0]  off_ff, off_in;
   logic [2:0]  idx_ff, idx_in;

   logic [2:0]  n_req, wr_n, take;
   logic [31:0] wr_word;
   logic [1:0]  wr_off;
   logic [6:0]  space;
   logic        full;
   logic [31:0] a, b, c, d, e, f, k, w, tmp;

   // Byte count of the incoming beat, with counts above four taken as four.
   assign n_req   = (req_valid_bytes > sha1sh_pkg::MAX_BYTES) ? sha1sh_pkg::MAX_BYTES
                                                              : req_valid_bytes;
   assign wr_word = cmd.rest ? pend_ff : req_data_word;
   assign wr_n    = cmd.rest ? rem_ff : n_req;
   assign wr_off  = cmd.rest ? off_ff : 2'd0;
   assign space   = 7'd64 - {1'b0, fill_ff};
   assign full    = ({4'd0, wr_n} >= space);
   assign take    = full ? space[2:0] : wr_n;

   // Round function inputs; the first round starts from the chaining value.
   always_comb begin
      if (round_ff == 7'd0) begin
         a = h_ff[0]; b = h_ff[1]; c = h_ff[2]; d = h_ff[3]; e = h_ff[4];
      end else begin
         a = wv_ff[0]; b = wv_ff[1]; c = wv_ff[2]; d = wv_ff[3]; e = wv_ff[4];
      end
      if (round_ff < 7'd20) begin
         f = (b & c) | (~b & d);
         k = sha1sh_pkg::K0;
      end else if (round_ff < 7'd40) begin
         f = b ^ c ^ d;
         k = sha1sh_pkg::K1;
      end else if (round_ff < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
         k = sha1sh_pkg::K2;
      end else begin
         f = b ^ c ^ d;
         k = sha1sh_pkg::K3;
      end
      if (round_ff < 7'd16) begin
         w = wbuf_ff[0];
      end else begin
         w = sha1sh_pkg::rotl1(wbuf_ff[13] ^ wbuf_ff[8] ^ wbuf_ff[2] ^ wbuf_ff[0]);
      end
      tmp = sha1sh_pkg::rotl5(a) + f + e + k + w;
   end

   // Next state of the buffer, which doubles as the schedule window.
   always_comb begin
      logic [5:0] pos;
      logic [1:0] sel;
      for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS; i++) begin
         wbuf_in[i] = wbuf_ff[i];
      end
      pos = '0;
      sel = '0;
      if (cmd.accept || cmd.rest) begin
         for (int j = 0; j < 4; j++) begin
            if (3'(j) < take) begin
               pos = fill_ff + 6'(j);
               sel = wr_off + 2'(j);
               wbuf_in[pos[5:2]][8*(3 - int'(pos[1:0])) +: 8] =
                  wr_word[8*(3 - int'(sel)) +: 8];
            end
         end
      end else if (cmd.pad) begin
         for (int p = 0; p < sha1sh_pkg::BLOCK_BYTES; p++) begin
            if (6'(p) == fill_ff) begin
               wbuf_in[p / 4][8*(3 - p % 4) +: 8] = sha1sh_pkg::PAD_BYTE;
            end else if (6'(p) > fill_ff) begin
               wbuf_in[p / 4][8*(3 - p % 4) +: 8] = 8'd0;
            end
         end
         if (fill_ff < sha1sh_pkg::LEN_START) begin
            wbuf_in[14] = bits_ff[63:32];
            wbuf_in[15] = bits_ff[31:0];
         end
      end else if (cmd.len) begin
         for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS - 2; i++) begin
            wbuf_in[i] = '0;
         end
         wbuf_in[14] = bits_ff[63:32];
         wbuf_in[15] = bits_ff[31:0];
      end else if (cmd.round) begin
         for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS - 1; i++) begin
            wbuf_in[i] = wbuf_ff[i + 1];
         end
         wbuf_in[15] = w;
      end
   end

   // Working variables, chaining value and counters.
   always_comb begin
      wv_in[0] = tmp;
      wv_in[1] = a;
      wv_in[2] = sha1sh_pkg::rotl30(b);
      wv_in[3] = c;
      wv_in[4] = d;
      for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
         h_in[i] = h_ff[i];
      end
      if (cmd.reinit) begin
         h_in[0] = sha1sh_pkg::IV0; h_in[1] = sha1sh_pkg::IV1;
         h_in[2] = sha1sh_pkg::IV2; h_in[3] = sha1sh_pkg::IV3;
         h_in[4] = sha1sh_pkg::IV4;
      end else if (cmd.round && sts.last_round) begin
         for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
            h_in[i] = h_ff[i] + wv_in[i];
         end
      end

      fill_in = fill_ff;
      bits_in = bits_ff;
      if (cmd.reinit) begin
         fill_in = '0;
         bits_in = '0;
      end else if (cmd.accept || cmd.rest) begin
         fill_in = fill_ff + {3'd0, take};
         if (cmd.accept) begin
            bits_in = bits_ff + {58'd0, n_req, 3'd0};
         end
      end

      round_in = round_ff;
      if (cmd.round) begin
         round_in = sts.last_round ? 7'd0 : round_ff + 7'd1;
      end

      pend_in = pend_ff;
      rem_in  = rem_ff;
      off_in  = off_ff;
      if (cmd.accept) begin
         pend_in = req_data_word;
         rem_in  = wr_n - take;
         off_in  = take[1:0];
      end

      idx_in = idx_ff;
      if (cmd.reinit) begin
         idx_in = '0;
      end else if (cmd.out_next) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0]  <= sha1sh_pkg::IV0;
         h_ff[1]  <= sha1sh_pkg::IV1;
         h_ff[2]  <= sha1sh_pkg::IV2;
         h_ff[3]  <= sha1sh_pkg::IV3;
         h_ff[4]  <= sha1sh_pkg::IV4;
         fill_ff  <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         h_ff     <= h_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wbuf_ff <= wbuf_in;
      if (cmd.round) begin
         wv_ff <= wv_in;
      end
      pend_ff <= pend_in;
      rem_ff  <= rem_in;
      off_ff  <= off_in;
   end

   assign sts.full       = full;
   assign sts.rem_nz     = (rem_ff != 3'd0);
   assign sts.last_round = (round_ff == sha1sh_pkg::LAST_ROUND);
   assign sts.pad_two    = (fill_ff >= sha1sh_pkg::LEN_START);
   assign sts.out_last   = (idx_ff == sha1sh_pkg::LAST_INDEX);

   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_result = (idx_ff == sha1sh_pkg::LAST_INDEX);

   // The round counter rests at zero between compressions.
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      !cmd.round |-> (round_ff == 7'd0))
      else $error("round counter left mid-compression");

   // A new message starts empty.
   a_reinit: assert property (@(posedge clock) disable iff (reset)
      cmd.reinit |=> (fill_ff == 6'd0) && (bits_ff == 64'd0) && (idx_ff == 3'd0))
      else $error("message state not cleared after digest");

   // The digest index never runs past the fifth word.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= sha1sh_pkg::LAST_INDEX)
      else $error("digest index out of range");

endmodule

/* hdl/sha1sh_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1sh_ctrl
// Sequencer for word intake, compression, padding and digest output.
// ----------------------------------------------------------------------------
module sha1sh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_word,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha1sh_pkg::cmd_type cmd,
   input  sha1sh_pkg::sts_type sts
);

   sha1sh_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1sh_pkg::ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         sha1sh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               last_in    = req_last_word;
               if (sts.full) begin
                  state_in = sha1sh_pkg::ST_COMP_DATA;
               end else if (req_last_word) begin
                  state_in = sha1sh_pkg::ST_PAD;
               end
            end
         end
         sha1sh_pkg::ST_COMP_DATA: begin
            cmd.round = 1'b1;
            if (sts.last_round) begin
               if (sts.rem_nz) begin
                  state_in = sha1sh_pkg::ST_REST;
               end else if (last_ff) begin
                  state_in = sha1sh_pkg::ST_PAD;
               end else begin
                  state_in = sha1sh_pkg::ST_IDLE;
               end
            end
         end
         sha1sh_pkg::ST_REST: begin
            cmd.rest = 1'b1;
            state_in = last_ff ? sha1sh_pkg::ST_PAD : sha1sh_pkg::ST_IDLE;
         end
         sha1sh_pkg::ST_PAD: begin
            cmd.pad  = 1'b1;
            state_in = sts.pad_two ? sha1sh_pkg::ST_COMP_PAD : sha1sh_pkg::ST_COMP_FINAL;
         end
         sha1sh_pkg::ST_COMP_PAD: begin
            cmd.round = 1'b1;
            if (sts.last_round) begin
               state_in = sha1sh_pkg::ST_LEN;
            end
         end
         sha1sh_pkg::ST_LEN: begin
            cmd.len  = 1'b1;
            state_in = sha1sh_pkg::ST_COMP_FINAL;
         end
         sha1sh_pkg::ST_COMP_FINAL: begin
            cmd.round = 1'b1;
            if (sts.last_round) begin
               state_in = sha1sh_pkg::ST_OUT;
            end
         end
         sha1sh_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.out_next = 1'b1;
               if (sts.out_last) begin
                  cmd.reinit = 1'b1;
                  state_in   = sha1sh_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha1sh_pkg::ST_IDLE;
      endcase
   end

   // The final compression always hands over to digest output.
   a_final_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1sh_pkg::ST_COMP_FINAL && sts.last_round)
      |=> (state_ff == sha1sh_pkg::ST_OUT))
      else $error("final compression did not lead to output");

   // A single pad block goes straight to the final compression.
   a_pad_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1sh_pkg::ST_PAD && !sts.pad_two)
      |=> (state_ff == sha1sh_pkg::ST_COMP_FINAL))
      else $error("single pad block took the two-block path");

   // Intake and digest output are never offered in the same cycle.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and output offered together");

endmodule

/* hdl/sha1_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top
// Streaming SHA-1: message words in, five digest words out per message.
// ----------------------------------------------------------------------------
//  channel  direction  beat
//  req_if   in         data_word, valid_bytes, last_word
//  rsp_if   out        digest_word, word_index, last_result
//
// A word that does not fill the block is only stored. A word that completes
// the 64-byte block starts 80 rounds (one round per cycle in the shared
// round unit), then a rest step for bytes spilling into the next block.
// The last word adds a pad step and 80 rounds, or pad and length steps and 160
// rounds for two pad blocks, then five output beats at the consumer's pace.
// Reset is synchronous; the block is ready for a new message straight after.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_top (
   input  logic         clock,
   input  logic         reset,
   sha1sh_req_if.sink   req_if,
   sha1sh_rsp_if.source rsp_if
);

   sha1sh_pkg::cmd_type cmd;
   sha1sh_pkg::sts_type sts;

   // Sequencer.
   sha1sh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_last_word (req_if.last_word),
      .req_ready     (req_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .cmd           (cmd),
      .sts           (sts)
   );

   // Hash datapath.
   sha1sh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_data_word   (req_if.data_word),
      .req_valid_bytes (req_if.valid_bytes),
      .rsp_digest_word (rsp_if.digest_word),
      .rsp_word_index  (rsp_if.word_index),
      .rsp_last_result (rsp_if.last_result)
   );

endmodule

/* verif/sha1_stream_hasher_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top_tb
// Drives messages of random length and byte packing into the SHA-1 hasher
// and checks each digest word against a behavioural SHA-1 written here.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_top_tb;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_result;
   } digest_beat_type;

   typedef struct {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } msg_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1sh_req_if req_if ();
   sha1sh_rsp_if rsp_if ();

   sha1_stream_hasher_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always #1 clock = ~clock;

   // Predictor state: one SHA-1 context.
   logic [31:0]  hash_state [5];
   logic [7:0]   byte_buf [64];
   int unsigned  buf_fill;
   logic [63:0]  bit_count;

   digest_beat_type digest_q [$];
   int unsigned  error_count;
   int unsigned  beats_sent;
   int unsigned  digests_seen;
   int unsigned  digests_checked;
   bit           stim_done;
   bit           hold_off;
   bit           hold_done;

   function automatic logic [31:0] rot(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   // One 80-round compression of byte_buf into hash_state.
   task automatic compress_buffer();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, wt, t;
      for (int i = 0; i < 16; i++)
         w[i] = {byte_buf[4*i], byte_buf[4*i+1], byte_buf[4*i+2], byte_buf[4*i+3]};
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
      d = hash_state[3]; e = hash_state[4];
      for (int r = 0; r < sha1sh_pkg::ROUNDS; r++) begin
         if (r >= 16) begin
            wt = rot(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
            w[r%16] = wt;
         end else begin
            wt = w[r];
         end
         if (r < 20) begin
            f = (b & c) | (~b & d); k = sha1sh_pkg::K0;
         end else if (r < 40) begin
            f = b ^ c ^ d; k = sha1sh_pkg::K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d); k = sha1sh_pkg::K2;
         end else begin
            f = b ^ c ^ d; k = sha1sh_pkg::K3;
         end
         t = rot(a, 5) + f + e + k + wt;
         e = d; d = c; c = rot(b, 30); b = a; a = t;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
      hash_state[3] += d; hash_state[4] += e;
   endtask

   task automatic restart_message();
      hash_state[0] = sha1sh_pkg::IV0; hash_state[1] = sha1sh_pkg::IV1;
      hash_state[2] = sha1sh_pkg::IV2; hash_state[3] = sha1sh_pkg::IV3;
      hash_state[4] = sha1sh_pkg::IV4;
      buf_fill  = 0;
      bit_count = '0;
   endtask

   // Fold one accepted beat into the context; on the last word queue the digest.
   task automatic absorb_beat(input msg_beat_type m);
      int unsigned n;
      digest_beat_type d;
      n = (m.valid_bytes > sha1sh_pkg::MAX_BYTES) ? sha1sh_pkg::MAX_BYTES : m.valid_bytes;
      for (int i = 0; i < n; i++) begin
         byte_buf[buf_fill] = m.data_word[31 - 8*i -: 8];
         buf_fill++;
         if (buf_fill == sha1sh_pkg::BLOCK_BYTES) begin
            compress_buffer();
            buf_fill = 0;
         end
      end
      bit_count += 64'(n * 8);
      if (!m.last_word)
         return;
      byte_buf[buf_fill] = sha1sh_pkg::PAD_BYTE;
      for (int i = buf_fill + 1; i < sha1sh_pkg::BLOCK_BYTES; i++)
         byte_buf[i] = 8'h00;
      if (buf_fill >= sha1sh_pkg::LEN_START) begin
         compress_buffer();
         for (int i = 0; i < sha1sh_pkg::BLOCK_BYTES; i++)
            byte_buf[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++)
         byte_buf[56 + i] = bit_count[63 - 8*i -: 8];
      compress_buffer();
      for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
         d.digest_word = hash_state[i];
         d.word_index  = 3'(i);
         d.last_result = (i == sha1sh_pkg::DIGEST_WORDS - 1);
         digest_q.push_back(d);
      end
      digests_seen++;
      restart_message();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Monitor: input beats feed the predictor, digest beats are compared.
   always @(posedge clock) begin
      digest_beat_type exp_beat;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            msg_beat_type m;
            m.data_word   = req_if.data_word;
            m.valid_bytes = req_if.valid_bytes;
            m.last_word   = req_if.last_word;
            absorb_beat(m);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (digest_q.size() == 0) begin
               report_mismatch("unexpected digest beat", rsp_if.digest_word, 32'h0);
            end else begin
               exp_beat = digest_q.pop_front();
               if (rsp_if.digest_word !== exp_beat.digest_word)
                  report_mismatch("digest_word", rsp_if.digest_word, exp_beat.digest_word);
               if (rsp_if.word_index !== exp_beat.word_index)
                  report_mismatch("word_index", 32'(rsp_if.word_index),
                                  32'(exp_beat.word_index));
               if (rsp_if.last_result !== exp_beat.last_result)
                  report_mismatch("last_result", 32'(rsp_if.last_result),
                                  32'(exp_beat.last_result));
               if (exp_beat.last_result)
                  digests_checked++;
            end
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sender: one beat per handshake; valid drops only when a gap follows.
   task automatic send_beat(input logic [31:0] w, input logic [2:0] n, input logic l);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_word   <= w;
      req_if.valid_bytes <= n;
      req_if.last_word   <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      beats_sent++;
   endtask

   // A message of random length; byte counts are mostly full words.
   task automatic send_message(input int unsigned nbeats, input bit messy);
      logic [2:0] n;
      for (int i = 0; i < nbeats; i++) begin
         if (messy)
            n = 3'($urandom_range(0, 7));
         else
            n = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 4))
                                            : sha1sh_pkg::MAX_BYTES;
         send_beat($urandom(), n, 1'b0);
      end
      send_beat($urandom(), 3'($urandom_range(0, 4)), 1'b1);
   endtask

   // Directed table: packing extremes, empty message, pad boundaries.
   localparam int DIR_ROWS = 22;
   msg_beat_type dir_table [DIR_ROWS] = '{
      // "abc": digest a9993e36 4706816a ba3e2571 7850c26c 9cd0d89d
      '{32'h61626300, 3'd3, 1'b1},
      // empty message: da39a3ee 5e6b4b0d 3255bfef 95601890 afd80709
      '{32'h00000000, 3'd0, 1'b1},
      // counts above four and zero mid-message
      '{32'hffffffff, 3'd7, 1'b0}, '{32'h12345678, 3'd0, 1'b0},
      '{32'h00000000, 3'd5, 1'b0}, '{32'hdeadbeef, 3'd6, 1'b1},
      // 14 full words then a last word with one byte crosses the two-pad threshold
      '{32'haaaaaaaa, 3'd4, 1'b0}, '{32'h55555555, 3'd4, 1'b0},
      '{32'hffffffff, 3'd4, 1'b0}, '{32'h00000000, 3'd4, 1'b0},
      '{32'h01020304, 3'd4, 1'b0}, '{32'h80808080, 3'd4, 1'b0},
      '{32'h7f7f7f7f, 3'd4, 1'b0}, '{32'hfedcba98, 3'd4, 1'b0},
      '{32'h11111111, 3'd4, 1'b0}, '{32'h22222222, 3'd4, 1'b0},
      '{32'h33333333, 3'd4, 1'b0}, '{32'h44444444, 3'd4, 1'b0},
      '{32'h66666666, 3'd4, 1'b0}, '{32'h77777777, 3'd4, 1'b0},
      '{32'h99999999, 3'd1, 1'b1},
      '{32'h00000001, 3'd1, 1'b1}
   };

   // Known digests of the first two rows, checked on top of the predictor.
   logic [31:0] abc_digest [5] = '{32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                   32'h7850c26c, 32'h9cd0d89d};
   logic [31:0] empty_digest [5] = '{32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                     32'h95601890, 32'hafd80709};
   int unsigned known_idx = 0;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready && known_idx < 10) begin
         if (known_idx < 5) begin
            if (rsp_if.digest_word !== abc_digest[known_idx])
               report_mismatch("abc digest", rsp_if.digest_word, abc_digest[known_idx]);
         end else if (rsp_if.digest_word !== empty_digest[known_idx - 5]) begin
            report_mismatch("empty digest", rsp_if.digest_word,
                            empty_digest[known_idx - 5]);
         end
         known_idx++;
      end
   end

   // Stimulus.
   initial begin
      int unsigned nb;
      req_if.valid       <= 1'b0;
      req_if.data_word   <= '0;
      req_if.valid_bytes <= '0;
      req_if.last_word   <= 1'b0;
      error_count = 0; beats_sent = 0; digests_seen = 0; digests_checked = 0;
      stim_done = 0; hold_off = 0; hold_done = 0;
      restart_message();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i])
         send_beat(dir_table[i].data_word, dir_table[i].valid_bytes,
                   dir_table[i].last_word);

      // Random messages until at least 235 beats are sent; one long receiver hold-off on the way.
      while (beats_sent < 235) begin
         if (beats_sent > 90 && !hold_done) begin
            hold_off  = 1;
            hold_done = 1;
         end
         nb = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 17);
         send_message(nb, $urandom_range(0, 4) == 0);
      end
      req_if.valid <= 1'b0;
      stim_done = 1;
   end

   // Receiver: random stalls, and one long hold-off that also holds back the sender once a digest waits.
   initial begin
      int unsigned gap;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 5) == 0) ? 0 : pick_gap();
         if (gap == 0) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // End of run.
   initial begin
      wait (stim_done);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Sent %0d message beats; %0d digests predicted, %0d checked in full.",
               beats_sent, digests_seen, digests_checked);
      if (error_count == 0 && digest_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("Timeout with %0d digest beats still awaited.", digest_q.size());
      $display("simulation failed");
      $finish;
   end

endmodule
